/* rtl/core/assert_macros.svh */
// assertion macros used by grouped_pnn50_hrv in this folder
// expects a clock named clk and a synchronous reset named rst in the using module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/core/gpnn_pkg.sv */
// shared types and constants for the grouped pnn50 block
// no dependencies
package gpnn_pkg;

  localparam int KEY_W    = 64;
  localparam int RR_W     = 20;
  localparam int PNN_W    = 14;
  localparam int RRCNT_W  = 24;
  localparam int SCALE_W  = 14;

  localparam logic [RR_W-1:0]    THRESH_RESET = RR_W'(800);
  localparam logic [SCALE_W-1:0] SCALE        = SCALE_W'(10000);

  // quotient never exceeds 10000, so 14 quotient bits are enough
  localparam int QUOT_W = 14;
  localparam int STEP_W = $clog2(QUOT_W + 1);

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE,
    ST_ALLOC,
    ST_RPT_DIV,
    ST_RPT_WAIT,
    ST_RPT_EMPTY
  } state_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_LOAD,
    DIV_RUN
  } div_state_t;

endpackage

/* rtl/core/gpnn_div.sv */
// iterative rounded divider: (above * 10000 + pairs / 2) / pairs
// one quotient bit per cycle; depends on gpnn_pkg
module gpnn_div #(
  parameter int CNT_W = 24
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [CNT_W-1:0]                above,
  input  logic [CNT_W-1:0]                pairs,
  output logic                            busy,
  output logic [gpnn_pkg::QUOT_W-1:0]     quot
);

  localparam int NUM_W = CNT_W + gpnn_pkg::SCALE_W;

  gpnn_pkg::div_state_t state, state_next;

  logic [NUM_W-1:0]                prod;
  logic [CNT_W-1:0]                divisor;
  logic [CNT_W-1:0]                rem;
  logic [gpnn_pkg::QUOT_W-1:0]     shreg;
  logic [gpnn_pkg::STEP_W-1:0]     step;
  logic [NUM_W-1:0]                num;
  logic [CNT_W:0]                  trial;
  logic                            qbit;

  always_comb begin
    state_next = state;
    case (state)
      gpnn_pkg::DIV_IDLE: if (start) state_next = gpnn_pkg::DIV_LOAD;
      gpnn_pkg::DIV_LOAD: state_next = gpnn_pkg::DIV_RUN;
      gpnn_pkg::DIV_RUN: begin
        if (step == gpnn_pkg::STEP_W'(1)) state_next = gpnn_pkg::DIV_IDLE;
      end
      default: state_next = gpnn_pkg::DIV_IDLE;
    endcase
  end

  always_comb begin
    num   = prod + NUM_W'(divisor >> 1);
    trial = {rem, shreg[gpnn_pkg::QUOT_W-1]};
    qbit  = (trial >= {1'b0, divisor});
    busy  = (state != gpnn_pkg::DIV_IDLE);
    quot  = shreg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gpnn_pkg::DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      gpnn_pkg::DIV_IDLE: begin
        if (start) begin
          prod    <= NUM_W'(above) * NUM_W'(gpnn_pkg::SCALE);
          divisor <= pairs;
        end
      end
      gpnn_pkg::DIV_LOAD: begin
        // top part of the dividend is already below the divisor
        rem   <= num[NUM_W-1:gpnn_pkg::SCALE_W];
        shreg <= num[gpnn_pkg::SCALE_W-1:0];
        step  <= gpnn_pkg::STEP_W'(gpnn_pkg::QUOT_W);
      end
      gpnn_pkg::DIV_RUN: begin
        if (qbit) begin
          rem <= CNT_W'(trial - {1'b0, divisor});
        end else begin
          rem <= trial[CNT_W-1:0];
        end
        shreg <= {shreg[gpnn_pkg::QUOT_W-2:0], qbit};
        step  <= step - gpnn_pkg::STEP_W'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/core/grouped_pnn50_hrv.sv */
// sample: accepted in idle, then ST_SEARCH walks the group table entry by entry and
//   ST_UPDATE or ST_ALLOC writes the record; a new key is dropped when the table is full
// report: per group ST_RPT_DIV starts the bit-serial divider and ST_RPT_WAIT waits for it
//   (start, load, 14 steps, hand-off) and result stalls; ST_RPT_EMPTY if empty; input held off
// a finished result sits in an output register, so the next item is taken while it waits
// synchronous active-high reset clears the group count and drop flag and sets the threshold to 800
`include "assert_macros.svh"

module grouped_pnn50_hrv #(
  parameter int MAX_GROUPS = 32,
  parameter int COUNT_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             op,
  input  logic [gpnn_pkg::KEY_W-1:0]       group_key,
  input  logic [gpnn_pkg::RR_W-1:0]        rr_interval,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [gpnn_pkg::KEY_W-1:0]       group_key_res,
  output logic [gpnn_pkg::PNN_W-1:0]       pnn50_hundredths,
  output logic [gpnn_pkg::RRCNT_W-1:0]     rr_count,
  output logic                             group_valid,
  output logic                             dropped,
  output logic                             last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gpnn_pkg::RR_W-1:0]        cfg_data
);

  localparam int IDX_W  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int USED_W = $clog2(MAX_GROUPS + 1);

  typedef struct packed {
    logic [gpnn_pkg::KEY_W-1:0] key;
    logic [gpnn_pkg::RR_W-1:0]  last_rr;
    logic [COUNT_BITS-1:0]      above;
    logic [COUNT_BITS-1:0]      pairs;
    logic [COUNT_BITS-1:0]      samples;
  } rec_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    sat_inc = (&v) ? v : v + COUNT_BITS'(1);
  endfunction

  gpnn_pkg::state_t state, state_next;

  rec_t                          mem [MAX_GROUPS];
  rec_t                          rd_data;
  rec_t                          wr_rec;
  logic                          wr_en;
  logic [IDX_W-1:0]              wr_addr;
  logic [IDX_W-1:0]              rd_addr;

  logic [IDX_W-1:0]              idx;
  logic [USED_W-1:0]             groups_used;
  logic                          drop_flag;
  logic [gpnn_pkg::RR_W-1:0]     diff_threshold;
  logic [gpnn_pkg::KEY_W-1:0]    key_q;
  logic [gpnn_pkg::RR_W-1:0]     rr_q;

  logic                          in_xfer;
  logic                          out_free;
  logic                          out_load;
  logic                          key_hit;
  logic                          idx_at_end;
  logic                          table_full;
  logic [gpnn_pkg::RR_W-1:0]     rr_diff;
  logic [31:0]                   samples_wide;

  logic                          div_start;
  logic                          div_busy;
  logic [gpnn_pkg::QUOT_W-1:0]   div_quot;

  logic [gpnn_pkg::KEY_W-1:0]    key_next;
  logic [gpnn_pkg::PNN_W-1:0]    pnn_next;
  logic [gpnn_pkg::RRCNT_W-1:0]  cnt_next;
  logic                          gvalid_next;
  logic                          last_next;

  gpnn_div #(
    .CNT_W (COUNT_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .above (rd_data.above),
    .pairs (rd_data.pairs),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != gpnn_pkg::ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign key_hit    = (rd_data.key == key_q);
  assign idx_at_end = ((USED_W'(idx) + USED_W'(1)) == groups_used);
  assign table_full = (groups_used == USED_W'(MAX_GROUPS));
  assign rr_diff    = (rr_q > rd_data.last_rr) ? rr_q - rd_data.last_rr
                                               : rd_data.last_rr - rr_q;
  assign samples_wide = 32'(rd_data.samples);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      gpnn_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (op == gpnn_pkg::OP_REPORT) begin
            state_next = (groups_used == '0) ? gpnn_pkg::ST_RPT_EMPTY : gpnn_pkg::ST_RPT_DIV;
          end else begin
            state_next = (groups_used == '0) ? gpnn_pkg::ST_ALLOC : gpnn_pkg::ST_SEARCH;
          end
        end
      end
      gpnn_pkg::ST_SEARCH: begin
        if (key_hit) begin
          state_next = gpnn_pkg::ST_UPDATE;
        end else if (idx_at_end) begin
          state_next = table_full ? gpnn_pkg::ST_IDLE : gpnn_pkg::ST_ALLOC;
        end
      end
      gpnn_pkg::ST_UPDATE:  state_next = gpnn_pkg::ST_IDLE;
      gpnn_pkg::ST_ALLOC:   state_next = gpnn_pkg::ST_IDLE;
      gpnn_pkg::ST_RPT_DIV: state_next = gpnn_pkg::ST_RPT_WAIT;
      gpnn_pkg::ST_RPT_WAIT: begin
        if (!div_busy && out_free) begin
          state_next = idx_at_end ? gpnn_pkg::ST_IDLE : gpnn_pkg::ST_RPT_DIV;
        end
      end
      gpnn_pkg::ST_RPT_EMPTY: begin
        if (out_free) state_next = gpnn_pkg::ST_IDLE;
      end
      default: state_next = gpnn_pkg::ST_IDLE;
    endcase
  end

  // control and datapath selects
  always_comb begin
    rd_addr     = idx;
    wr_en       = 1'b0;
    wr_addr     = idx;
    wr_rec      = rd_data;
    div_start   = 1'b0;
    out_load    = 1'b0;
    key_next    = rd_data.key;
    pnn_next    = (rd_data.pairs == '0) ? '0 : gpnn_pkg::PNN_W'(div_quot);
    cnt_next    = samples_wide[gpnn_pkg::RRCNT_W-1:0];
    gvalid_next = 1'b1;
    last_next   = idx_at_end;
    case (state)
      gpnn_pkg::ST_IDLE: begin
        if (in_xfer) rd_addr = '0;
      end
      gpnn_pkg::ST_SEARCH: begin
        if (!key_hit && !idx_at_end) rd_addr = idx + IDX_W'(1);
      end
      gpnn_pkg::ST_UPDATE: begin
        wr_en          = 1'b1;
        wr_rec.last_rr = rr_q;
        wr_rec.pairs   = sat_inc(rd_data.pairs);
        wr_rec.samples = sat_inc(rd_data.samples);
        if (rr_diff > diff_threshold) wr_rec.above = sat_inc(rd_data.above);
      end
      gpnn_pkg::ST_ALLOC: begin
        wr_en          = 1'b1;
        wr_addr        = groups_used[IDX_W-1:0];
        wr_rec.key     = key_q;
        wr_rec.last_rr = rr_q;
        wr_rec.above   = '0;
        wr_rec.pairs   = '0;
        wr_rec.samples = COUNT_BITS'(1);
      end
      gpnn_pkg::ST_RPT_DIV: begin
        div_start = 1'b1;
      end
      gpnn_pkg::ST_RPT_WAIT: begin
        if (!div_busy && out_free) begin
          out_load = 1'b1;
          if (!idx_at_end) rd_addr = idx + IDX_W'(1);
        end
      end
      gpnn_pkg::ST_RPT_EMPTY: begin
        out_load    = out_free;
        key_next    = '0;
        pnn_next    = '0;
        cnt_next    = '0;
        gvalid_next = 1'b0;
        last_next   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // group table, registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_rec;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= gpnn_pkg::ST_IDLE;
      groups_used    <= '0;
      drop_flag      <= 1'b0;
      diff_threshold <= gpnn_pkg::THRESH_RESET;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) diff_threshold <= cfg_data;
      if (state == gpnn_pkg::ST_ALLOC) groups_used <= groups_used + USED_W'(1);
      if (state == gpnn_pkg::ST_SEARCH && !key_hit && idx_at_end && table_full) begin
        drop_flag <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      key_q <= group_key;
      rr_q  <= rr_interval;
      idx   <= '0;
    end else if (rd_addr != idx) begin
      idx <= rd_addr;
    end
    if (out_load) begin
      group_key_res    <= key_next;
      pnn50_hundredths <= pnn_next;
      rr_count         <= cnt_next;
      group_valid      <= gvalid_next;
      dropped          <= drop_flag;
      last             <= last_next;
    end
  end

  `ASSERT_ALWAYS(a_used_bound, groups_used <= USED_W'(MAX_GROUPS), "group count past table size")
  `ASSERT_SAME(a_div_idle, state == gpnn_pkg::ST_IDLE, !div_busy, "divider busy while idle")
  `ASSERT_NEXT(a_last_idle, out_load && last_next, state == gpnn_pkg::ST_IDLE, "report run did not end")
  `ASSERT_NEXT(a_drop_sticky, drop_flag, drop_flag, "drop flag cleared outside reset")
  `ASSERT_SAME(a_alloc_room, state == gpnn_pkg::ST_ALLOC, !table_full, "allocation into full table")

endmodule

/* test/tb_grouped_pnn50_hrv.sv */
// self-checking testbench for grouped_pnn50_hrv: directed and random rr samples and reports
// a scoreboard class predicts every report transfer; depends on gpnn_pkg and the block's rtl
module tb_grouped_pnn50_hrv;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_GROUPS    = 32;
  localparam int COUNT_BITS    = 24;
  localparam int SETTLE_CYCLES = 64;
  localparam int LONG_HOLD     = 400;
  localparam int DRAIN_LIMIT   = 200000;

  typedef struct packed {
    logic [gpnn_pkg::KEY_W-1:0]   key;
    logic [gpnn_pkg::PNN_W-1:0]   pnn;
    logic [gpnn_pkg::RRCNT_W-1:0] count;
    logic                         grp_valid;
    logic                         drop;
    logic                         last_flag;
  } group_report_t;

  class pnn50_scoreboard;
    logic [gpnn_pkg::RR_W-1:0]  threshold;
    logic [gpnn_pkg::KEY_W-1:0] keys     [MAX_GROUPS];
    logic [gpnn_pkg::RR_W-1:0]  prev_rr  [MAX_GROUPS];
    logic [COUNT_BITS-1:0]      above    [MAX_GROUPS];
    logic [COUNT_BITS-1:0]      pairs    [MAX_GROUPS];
    logic [COUNT_BITS-1:0]      samples  [MAX_GROUPS];
    int                         used;
    logic                       drop_seen;
    group_report_t              report_q [$];
    int                         errors;

    function new();
      threshold = gpnn_pkg::THRESH_RESET;
      used      = 0;
      drop_seen = 1'b0;
      errors    = 0;
    endfunction

    function logic [COUNT_BITS-1:0] bump(logic [COUNT_BITS-1:0] v);
      return (v == {COUNT_BITS{1'b1}}) ? v : v + 1'b1;
    endfunction

    function int pending();
      return report_q.size();
    endfunction

    // update the group table for an accepted input and queue any report it causes
    function void note_input(logic o, logic [gpnn_pkg::KEY_W-1:0] k,
                             logic [gpnn_pkg::RR_W-1:0] rr);
      int                         hit;
      logic [gpnn_pkg::RR_W-1:0]  d;
      longint unsigned            p;
      group_report_t              r;
      if (o == gpnn_pkg::OP_SAMPLE) begin
        hit = -1;
        for (int g = 0; g < used; g++)
          if (hit < 0 && keys[g] == k) hit = g;
        if (hit >= 0) begin
          d = (rr > prev_rr[hit]) ? rr - prev_rr[hit] : prev_rr[hit] - rr;
          pairs[hit] = bump(pairs[hit]);
          if (d > threshold) above[hit] = bump(above[hit]);
          samples[hit] = bump(samples[hit]);
          prev_rr[hit] = rr;
        end else if (used >= MAX_GROUPS) begin
          drop_seen = 1'b1;
        end else begin
          keys[used]    = k;
          prev_rr[used] = rr;
          above[used]   = '0;
          pairs[used]   = '0;
          samples[used] = COUNT_BITS'(1);
          used++;
        end
      end else if (used == 0) begin
        r           = '0;
        r.drop      = drop_seen;
        r.last_flag = 1'b1;
        report_q.push_back(r);
      end else begin
        for (int g = 0; g < used; g++) begin
          p = pairs[g];
          r.key = keys[g];
          if (p == 0) r.pnn = '0;
          else r.pnn = gpnn_pkg::PNN_W'((longint'(above[g]) * 10000 + p / 2) / p);
          r.count     = gpnn_pkg::RRCNT_W'(samples[g]);
          r.grp_valid = 1'b1;
          r.drop      = drop_seen;
          r.last_flag = (g == used - 1);
          report_q.push_back(r);
        end
      end
    endfunction

    function void check_result(group_report_t got);
      group_report_t exp;
      if (report_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result transfer: key %h pnn %0d count %0d gv %b drop %b last %b",
                   got.key, got.pnn, got.count, got.grp_valid, got.drop, got.last_flag);
        return;
      end
      exp = report_q.pop_front();
      if (exp !== got) begin
        errors++;
        if (errors <= 10) begin
          $display("result differs at %0t", $realtime);
          $display("  exp: key %h pnn %0d count %0d gv %b drop %b last %b",
                   exp.key, exp.pnn, exp.count, exp.grp_valid, exp.drop, exp.last_flag);
          $display("  got: key %h pnn %0d count %0d gv %b drop %b last %b",
                   got.key, got.pnn, got.count, got.grp_valid, got.drop, got.last_flag);
        end
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst         = 1'b1;
  logic                           in_valid    = 1'b0;
  logic                           in_stall;
  logic                           op          = gpnn_pkg::OP_SAMPLE;
  logic [gpnn_pkg::KEY_W-1:0]     group_key   = '0;
  logic [gpnn_pkg::RR_W-1:0]      rr_interval = '0;
  logic                           out_valid;
  logic                           out_stall   = 1'b0;
  logic [gpnn_pkg::KEY_W-1:0]     group_key_res;
  logic [gpnn_pkg::PNN_W-1:0]     pnn50_hundredths;
  logic [gpnn_pkg::RRCNT_W-1:0]   rr_count;
  logic                           group_valid;
  logic                           dropped;
  logic                           last;
  logic                           cfg_valid   = 1'b0;
  logic                           cfg_ready;
  logic [gpnn_pkg::RR_W-1:0]      cfg_data    = '0;

  pnn50_scoreboard                sb;
  bit                             idle_on     = 1'b1;
  bit                             long_hold   = 1'b0;
  int                             stall_left  = 0;
  logic [gpnn_pkg::KEY_W-1:0]     key_pool [$];
  logic [gpnn_pkg::KEY_W-1:0]     prev_key    = '0;
  logic [gpnn_pkg::RR_W-1:0]      prev_rr     = '0;

  grouped_pnn50_hrv #(
    .MAX_GROUPS (MAX_GROUPS),
    .COUNT_BITS (COUNT_BITS)
  ) uut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .op               (op),
    .group_key        (group_key),
    .rr_interval      (rr_interval),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .group_key_res    (group_key_res),
    .pnn50_hundredths (pnn50_hundredths),
    .rr_count         (rr_count),
    .group_valid      (group_valid),
    .dropped          (dropped),
    .last             (last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // result side: check each transfer, then pick the stall for the next cycle
  always @(posedge clk) begin : result_side
    group_report_t got;
    if (!rst && out_valid && !out_stall) begin
      got.key       = group_key_res;
      got.pnn       = pnn50_hundredths;
      got.count     = rr_count;
      got.grp_valid = group_valid;
      got.drop      = dropped;
      got.last_flag = last;
      sb.check_result(got);
    end
    if (long_hold) begin
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_item(input logic o, input logic [gpnn_pkg::KEY_W-1:0] k,
                           input logic [gpnn_pkg::RR_W-1:0] rr);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= o;
    group_key   <= k;
    rr_interval <= rr;
    do @(posedge clk); while (in_stall);
    sb.note_input(o, k, rr);
  endtask

  task automatic write_threshold(input logic [gpnn_pkg::RR_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.threshold = v;
    cfg_valid <= 1'b0;
  endtask

  // samples cause no results, so give the key search time to finish too
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int n_items, input int new_pct);
    logic [gpnn_pkg::KEY_W-1:0] k;
    logic [gpnn_pkg::RR_W-1:0]  rr;
    logic [gpnn_pkg::RR_W:0]    step;
    int                         sel;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        send_item(gpnn_pkg::OP_REPORT, {$urandom, $urandom}, gpnn_pkg::RR_W'($urandom));
      end else begin
        if (key_pool.size() == 0 || $urandom_range(0, 99) < new_pct) begin
          k = {$urandom, $urandom};
          key_pool.push_back(k);
        end else begin
          k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        end
        sel = $urandom_range(0, 9);
        case (sel)
          0: rr = gpnn_pkg::RR_W'($urandom);
          1: rr = $urandom_range(0, 1) ? '0 : '1;
          2, 3: begin
            // step right at the threshold or one past it on the previous group
            k    = prev_key;
            step = {1'b0, sb.threshold} + ((sel == 3) ? (gpnn_pkg::RR_W + 1)'(1)
                                                      : (gpnn_pkg::RR_W + 1)'(0));
            if ({1'b0, prev_rr} + step <= {1'b0, {gpnn_pkg::RR_W{1'b1}}})
              rr = prev_rr + step[gpnn_pkg::RR_W-1:0];
            else if ({1'b0, prev_rr} >= step)
              rr = prev_rr - step[gpnn_pkg::RR_W-1:0];
            else
              rr = prev_rr;
          end
          default: rr = gpnn_pkg::RR_W'(13000 + $urandom_range(0, 3000));
        endcase
        send_item(gpnn_pkg::OP_SAMPLE, k, rr);
        prev_key = k;
        prev_rr  = rr;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table, then extremes of key and rr at the reset threshold
    send_item(gpnn_pkg::OP_REPORT, '1, '1);
    send_item(gpnn_pkg::OP_SAMPLE, '0, '0);
    send_item(gpnn_pkg::OP_SAMPLE, '0, '1);
    send_item(gpnn_pkg::OP_SAMPLE, '0,
              {gpnn_pkg::RR_W{1'b1}} - gpnn_pkg::RR_W'(gpnn_pkg::THRESH_RESET));
    send_item(gpnn_pkg::OP_SAMPLE, '1, gpnn_pkg::RR_W'(16000));
    send_item(gpnn_pkg::OP_SAMPLE, '1, gpnn_pkg::RR_W'(16000));
    send_item(gpnn_pkg::OP_SAMPLE, 64'h8000_0000_0000_0001, gpnn_pkg::RR_W'(1));
    send_item(gpnn_pkg::OP_REPORT, '0, '0);
    wait_idle();

    write_threshold('0);
    send_item(gpnn_pkg::OP_SAMPLE, '1, gpnn_pkg::RR_W'(16000));
    send_item(gpnn_pkg::OP_SAMPLE, '1, gpnn_pkg::RR_W'(16001));
    send_item(gpnn_pkg::OP_REPORT, '0, '0);
    wait_idle();

    // widest threshold: even a full-scale jump is not above it
    write_threshold('1);
    send_item(gpnn_pkg::OP_SAMPLE, '0, '0);
    send_item(gpnn_pkg::OP_SAMPLE, '0, '1);
    send_item(gpnn_pkg::OP_REPORT, '0, '0);
    wait_idle();

    key_pool.push_back('0);
    key_pool.push_back('1);
    write_threshold(gpnn_pkg::RR_W'($urandom_range(200, 4000)));
    run_phase(100, 15);
    wait_idle();

    // results back up behind a long receiver hold while reports keep coming
    write_threshold('0);
    fork
      begin
        long_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold <= 1'b0;
      end
    join_none
    for (int i = 0; i < 6; i++) send_item(gpnn_pkg::OP_REPORT, '0, '0);
    run_phase(90, 15);
    wait_idle();

    // enough new keys to fill the table and start dropping
    write_threshold('1);
    run_phase(90, 30);
    wait_idle();

    write_threshold(gpnn_pkg::THRESH_RESET);
    idle_on = 1'b0;
    run_phase(90, 10);
    send_item(gpnn_pkg::OP_REPORT, '0, '0);
    in_valid <= 1'b0;

    for (int guard = 0; guard < DRAIN_LIMIT && sb.pending() != 0; guard++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("grouped_pnn50_hrv: match");
    end else begin
      $display("grouped_pnn50_hrv: mismatch");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("grouped_pnn50_hrv: mismatch");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/gpnn_pkg.sv
rtl/core/gpnn_div.sv
rtl/core/grouped_pnn50_hrv.sv
test/tb_grouped_pnn50_hrv.sv
